>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL. They compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge. The check is off while reset is high.
`define ASSERT_CLKRST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_CLK(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKRST(name, clk, rst, prop, msg)
`define ASSERT_CLK(name, clk, prop, msg)

`endif

`endif

>>> rtl/tmwf_pkg.sv
package tmwf_pkg;

  // Window geometry.
  localparam int WINDOW   = 8;
  localparam int SAMPLE_W = 16;
  localparam int IDX_W    = $clog2(WINDOW);
  // The sum of the whole window fits in SUM_W bits.
  localparam int SUM_W    = SAMPLE_W + IDX_W;
  localparam int DIVISOR  = WINDOW - 2;

  // Division by DIVISOR is a multiply by a rounded-up reciprocal and a shift. The extra
  // clog2(DIVISOR) shift bits keep the result exact for every sum below 2**SUM_W.
  localparam int DIV_SHIFT = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [RECIP_W-1:0]  recip_t;
  typedef logic [PROD_W-1:0]   prod_t;

  localparam recip_t RECIP =
    recip_t'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam idx_t LAST_IDX = idx_t'(WINDOW - 1);
  // Largest sum of the entries that are left after trimming.
  localparam sum_t MAX_TRIM = sum_t'(DIVISOR * ((1 << SAMPLE_W) - 1));

  // Operation codes of a request.
  typedef enum logic {
    OP_SHIFT = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> rtl/tmwf_in_if.sv
interface tmwf_in_if;

  logic              valid;
  logic              ready;
  logic              operation;
  tmwf_pkg::sample_t sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);

endinterface

>>> rtl/tmwf_out_if.sv
interface tmwf_out_if;

  logic              valid;
  logic              ready;
  tmwf_pkg::sample_t trimmed_average;

  modport source (output valid, output trimmed_average, input ready);
  modport sink   (input valid, input trimmed_average, output ready);

endinterface

>>> rtl/trimmed_mean_window_filter.sv
// A request is accepted only in the idle state; the window scan reads one entry per cycle, then a
// trim step, a reciprocal-multiply step (skipped when all window entries are equal, as no division
// is needed) and the load into the output register follow, after which the block is idle again and
// can take the next request; it does not take a new request while one is in progress.
// A finished result waits in an output register; a held result stalls the next request.
// Reset (rst, synchronous, active high) clears the window to zero and empties the output.
`include "assert_macros.svh"

module trimmed_mean_window_filter
  import tmwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tmwf_in_if.sink    samples,
  tmwf_out_if.source averages
);

  state_t  state;
  state_t  state_next;
  sample_t window [WINDOW];
  idx_t    scan_idx;
  sum_t    sum;
  sample_t max_val;
  sample_t min_val;
  sum_t    trimmed_sum;
  sample_t quot;
  sample_t avg;
  logic    out_valid;

  logic    in_fire;
  logic    load_out;
  sample_t entry;
  prod_t   product;

  assign in_fire = samples.valid && samples.ready;
  assign entry   = window[scan_idx];
  assign product = prod_t'(trimmed_sum) * prod_t'(RECIP);

  // Handshake outputs of the sequencer.
  always_comb begin
    samples.ready = (state == ST_IDLE);
    load_out      = (state == ST_DONE) && (!out_valid || averages.ready);
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_SCAN;
      ST_SCAN: if (scan_idx == LAST_IDX) state_next = ST_TRIM;
      ST_TRIM: state_next = (max_val == min_val) ? ST_DONE : ST_DIV;
      ST_DIV:  state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window update on an accepted request: clear everything or shift in at the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) window[k] <= '0;
    end else if (in_fire) begin
      if (samples.operation == OP_CLEAR) begin
        for (int k = 0; k < WINDOW; k++) window[k] <= '0;
      end else begin
        for (int k = WINDOW - 1; k > 0; k--) window[k] <= window[k-1];
        window[0] <= samples.sample;
      end
    end
  end

  // Scan one entry per cycle, then trim and, unless all entries are equal, divide by a reciprocal multiply.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        scan_idx <= '0;
      end
      ST_SCAN: begin
        scan_idx <= scan_idx + idx_t'(1);
        if (scan_idx == '0) begin
          sum     <= sum_t'(entry);
          max_val <= entry;
          min_val <= entry;
        end else begin
          sum <= sum + sum_t'(entry);
          if (entry > max_val) max_val <= entry;
          if (entry < min_val) min_val <= entry;
        end
      end
      ST_TRIM: begin
        // Equal entries mean the same index is both max and min: report that value.
        quot        <= max_val;
        trimmed_sum <= sum - sum_t'(max_val) - sum_t'(min_val);
      end
      ST_DIV: begin
        quot <= sample_t'(product >> DIV_SHIFT);
      end
      default: begin
      end
    endcase
  end

  // Output register; it frees up as soon as the consumer takes the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) avg <= quot;
  end

  assign averages.valid           = out_valid;
  assign averages.trimmed_average = avg;

  // An accepted request starts a scan.
  `ASSERT_CLKRST(a_scan_start, clk, rst, in_fire |=> (state == ST_SCAN), "no scan")
  // The tracked maximum never falls below the tracked minimum.
  `ASSERT_CLKRST(a_max_ge_min, clk, rst, (state == ST_TRIM) |-> (max_val >= min_val), "max < min")
  // The trimmed sum stays small enough for the quotient to fit a sample.
  `ASSERT_CLKRST(a_div_in, clk, rst, (state == ST_DIV) |-> (trimmed_sum <= MAX_TRIM), "big sum")
  // A new result shows up only out of the done state.
  `ASSERT_CLKRST(a_load, clk, rst, $rose(out_valid) |-> $past(state == ST_DONE), "stray result")

endmodule

>>> sim/trimmed_mean_window_filter_test.sv
module trimmed_mean_window_filter_test;
  import tmwf_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  // Run-length bound that allows for full idling on both sides.
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_STALL   = 400;
  localparam int SETTLE       = WINDOW + 27;

  // Tracks the sample window and the averages still owed by the block.
  class average_scoreboard;
    sample_t window_entries[WINDOW];
    sample_t owed_averages[$];
    int      errors;
    int      requests;
    int      clears;
    int      flat_windows;
    int      checked;

    function new();
      foreach (window_entries[k]) begin
        window_entries[k] = '0;
      end
      errors       = 0;
      requests     = 0;
      clears       = 0;
      flat_windows = 0;
      checked      = 0;
    endfunction

    // Mean of the window with the first maximum and the first minimum left out.
    function sample_t compute_trimmed_mean();
      int          hi;
      int          lo;
      int unsigned acc;
      hi  = 0;
      lo  = 0;
      acc = 0;
      for (int k = 1; k < WINDOW; k++) begin
        if (window_entries[k] > window_entries[hi]) begin
          hi = k;
        end
        if (window_entries[k] < window_entries[lo]) begin
          lo = k;
        end
      end
      // A flat window picks one index for both, so the common value is returned.
      if (hi == lo) begin
        flat_windows++;
        return window_entries[0];
      end
      for (int k = 0; k < WINDOW; k++) begin
        if (k != hi && k != lo) begin
          acc += window_entries[k];
        end
      end
      return sample_t'(acc / (WINDOW - 2));
    endfunction

    // Applies an accepted request to the window and queues the owed average.
    function void note_request(op_t op, sample_t smp);
      requests++;
      if (op == OP_CLEAR) begin
        clears++;
        foreach (window_entries[k]) begin
          window_entries[k] = '0;
        end
      end else begin
        for (int k = WINDOW - 1; k > 0; k--) begin
          window_entries[k] = window_entries[k - 1];
        end
        window_entries[0] = smp;
      end
      owed_averages.push_back(compute_trimmed_mean());
    endfunction

    task report_mismatch(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    // Compares one delivered average with the oldest owed one.
    task check_average(sample_t got);
      sample_t want;
      if (owed_averages.size() == 0) begin
        report_mismatch($sformatf("average %h arrived with none owed", got));
      end else begin
        want = owed_averages.pop_front();
        checked++;
        if (got !== want) begin
          report_mismatch($sformatf("trimmed_average %h, expected %h (result %0d)",
                                    got, want, checked));
        end
      end
    endtask

    function int pending();
      return owed_averages.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  bit   calm;
  bit   long_stall_request;
  sample_t last_sample;
  average_scoreboard sb;

  tmwf_in_if  samples_if();
  tmwf_out_if averages_if();

  trimmed_mean_window_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if.sink),
    .averages (averages_if.source)
  );

  // Clock and known input values from time zero.
  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    samples_if.valid     = 1'b0;
    samples_if.operation = OP_SHIFT;
    samples_if.sample    = '0;
    averages_if.ready    = 1'b0;
    calm                 = 1'b0;
    long_stall_request   = 1'b0;
    last_sample          = '0;
    cycle_count          = 0;
    sb                   = new();
  end

  always #CLK_HALF clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ERROR: run exceeded %0d cycles", LIMIT_CYCLES);
      $display("FAIL trimmed_mean_window_filter");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && averages_if.valid && averages_if.ready) begin
      sb.check_average(averages_if.trimmed_average);
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  initial begin
    wait (rst == 1'b0);
    forever begin
      if (long_stall_request) begin
        long_stall_request = 1'b0;
        @(negedge clk);
        averages_if.ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        @(negedge clk);
        averages_if.ready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
      @(negedge clk);
      averages_if.ready = 1'b1;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  end

  // Offers one request and holds it until the block takes it.
  task send_request(op_t op, sample_t smp);
    @(negedge clk);
    samples_if.valid     = 1'b1;
    samples_if.operation = op;
    samples_if.sample    = smp;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_request(op, smp);
  endtask

  task idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      samples_if.valid = 1'b0;
    end
  endtask

  task maybe_idle();
    if (!calm && $urandom_range(0, 5) == 0) begin
      idle_input($urandom_range(1, 13));
    end
  endtask

  // Waits until every owed average has been delivered.
  task drain();
    idle_input(1);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sample mix: full range, extremes, repeats, near neighbors and single bits.
  function automatic sample_t pick_sample();
    int      mode;
    sample_t smp;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: smp = sample_t'($urandom_range(0, 65535));
      3: begin
        case ($urandom_range(0, 5))
          0: smp = 16'h0000;
          1: smp = 16'h0001;
          2: smp = 16'h7FFF;
          3: smp = 16'h8000;
          4: smp = 16'hFFFE;
          default: smp = 16'hFFFF;
        endcase
      end
      4, 5, 6: smp = last_sample;
      7, 8: smp = sample_t'(int'(last_sample) + $urandom_range(0, 6) - 3);
      default: smp = sample_t'(1 << $urandom_range(0, 15));
    endcase
    last_sample = smp;
    return smp;
  endfunction

  // Mostly shifts, now and then a clear or a flat run at least as long as the window.
  task random_requests(int count);
    int      sent;
    int      run_len;
    sample_t run_value;
    sent = 0;
    while (sent < count) begin
      maybe_idle();
      if ($urandom_range(0, 39) == 0) begin
        send_request(OP_CLEAR, sample_t'($urandom_range(0, 65535)));
        sent++;
      end else if ($urandom_range(0, 24) == 0) begin
        run_len   = $urandom_range(WINDOW, WINDOW + 4);
        run_value = pick_sample();
        repeat (run_len) begin
          maybe_idle();
          send_request(OP_SHIFT, run_value);
        end
        sent += run_len;
      end else begin
        send_request(OP_SHIFT, pick_sample());
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero window, clear with a stray sample, full-scale flat window,
    // duplicated extremes and alternating bit patterns.
    send_request(OP_SHIFT, 16'h0000);
    send_request(OP_CLEAR, 16'hABCD);
    repeat (WINDOW) send_request(OP_SHIFT, 16'hFFFF);
    send_request(OP_SHIFT, 16'h0000);
    send_request(OP_SHIFT, 16'h0001);
    send_request(OP_SHIFT, 16'h8000);
    send_request(OP_SHIFT, 16'h7FFF);
    send_request(OP_SHIFT, 16'hFFFF);
    send_request(OP_SHIFT, 16'h0000);
    send_request(OP_CLEAR, 16'hFFFF);
    send_request(OP_SHIFT, 16'h5555);
    send_request(OP_SHIFT, 16'hAAAA);
    send_request(OP_CLEAR, 16'h0000);
    drain();

    random_requests(800);

    // Long output hold-off while requests keep coming, then a full drain.
    long_stall_request = 1'b1;
    random_requests(40);
    drain();

    random_requests(800);

    // Last stretch with no idling on either side.
    calm = 1'b1;
    random_requests(260);
    drain();
    repeat (SETTLE) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d averages never arrived", sb.pending()));
    end
    $display("Run covered %0d requests (%0d clears, %0d flat windows) and %0d averages,",
             sb.requests, sb.clears, sb.flat_windows, sb.checked);
    $display("with random stalls, a long output hold-off and a full drain.");
    if (sb.errors == 0) begin
      $display("PASS trimmed_mean_window_filter");
    end else begin
      $display("FAIL trimmed_mean_window_filter");
    end
    $finish;
  end

endmodule
